// File: design/rmt_pkg.sv
// rmt_pkg: shared constants, types and state codes of the running median tracker
// depends on nothing; used by the interfaces, the cells, the group selects and the top level
`default_nettype none

package rmt_pkg;

	localparam int CAPACITY    = 256;
	localparam int SAMPLE_W    = 32;
	localparam int MEDIAN_W    = 33;
	localparam int COUNT_OUT_W = 9;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int GROUP_SIZE  = 16;
	localparam int GSEL_W      = $clog2(GROUP_SIZE);
	localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int GRP_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int PIDX_W      = GSEL_W + GRP_W;
	localparam int PAD_DEPTH   = NUM_GROUPS * GROUP_SIZE;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MEDIAN_W-1:0] median_t;
	typedef logic [CNT_W-1:0]           count_t;
	typedef logic [COUNT_OUT_W-1:0]     count_out_t;

	typedef struct packed {
		logic    en;
		sample_t sample;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GRP,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

// File: design/rmt_if.sv
// rmt_in_if and rmt_out_if: valid/ready channels for samples and median results
// depends on rmt_pkg for the payload types
`default_nettype none

interface rmt_in_if;
	logic              valid;
	logic              ready;
	rmt_pkg::sample_t  sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface rmt_out_if;
	logic                 valid;
	logic                 ready;
	rmt_pkg::median_t     median_twice;
	rmt_pkg::count_out_t  stored_count;
	logic                 full_drop;

	modport source (output valid, output median_twice, output stored_count,
		output full_drop, input ready);
	modport sink   (input valid, input median_twice, input stored_count,
		input full_drop, output ready);
endinterface

`default_nettype wire

// File: design/rmt_cell.sv
// rmt_cell: one cell of the sorted row; holds a value and shifts or takes the new sample
// depends on rmt_pkg for the sample and control types
`default_nettype none

module rmt_cell (
	input  wire logic                clk,
	input  wire rmt_pkg::cell_ctl_t  ctl,
	input  wire logic                occ,
	input  wire logic                left_gt,
	input  wire rmt_pkg::sample_t    left_val,
	output rmt_pkg::sample_t         val,
	output logic                     gt
);

	rmt_pkg::sample_t val_q;

	assign val = val_q;
	// occupied and strictly above the new sample
	assign gt  = occ && (val_q > ctl.sample);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt || !occ) begin
				val_q <= ctl.sample;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/rmt_group_sel.sv
// rmt_group_sel: picks the two middle candidates out of one group of cells into registers
// depends on rmt_pkg for widths and the sample type
`default_nettype none

module rmt_group_sel (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [rmt_pkg::GSEL_W-1:0]    lo_sel,
	input  wire logic [rmt_pkg::GSEL_W-1:0]    hi_sel,
	input  wire rmt_pkg::sample_t              vals [rmt_pkg::GROUP_SIZE],
	output rmt_pkg::sample_t                   lo_q,
	output rmt_pkg::sample_t                   hi_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			lo_q <= vals[lo_sel];
			hi_q <= vals[hi_sel];
		end
	end

endmodule

`default_nettype wire

// File: design/running_median_tracker_core.sv
// running_median_tracker_core: sorted row of cells with a two-level median readout
// readout: after an insert the group selects register, then the output registers load
// once the output is free; no new sample is taken until the result has been loaded
// reset: arst_n clears the count, state and output valid; cell contents are not cleared
// depends on rmt_pkg, rmt_if, rmt_cell and rmt_group_sel
`default_nettype none

module running_median_tracker_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rmt_in_if.sink      samples,
	rmt_out_if.source   results
);

	rmt_pkg::state_t    state_q, state_d;
	rmt_pkg::count_t    count_q;
	logic               drop_q;
	logic               acc;
	logic               grp_en;
	logic               fin_load;
	rmt_pkg::cell_ctl_t ctl;

	rmt_pkg::sample_t   cell_val [rmt_pkg::PAD_DEPTH];
	logic [rmt_pkg::CAPACITY-1:0] cell_gt;
	logic [rmt_pkg::CAPACITY-1:0] cell_occ;

	rmt_pkg::sample_t   grp_lo [rmt_pkg::NUM_GROUPS];
	rmt_pkg::sample_t   grp_hi [rmt_pkg::NUM_GROUPS];

	logic [rmt_pkg::IDX_W-1:0]  lo_idx, hi_idx;
	logic [rmt_pkg::PIDX_W-1:0] lo_pidx, hi_pidx;
	rmt_pkg::sample_t           lo_val, hi_val;
	rmt_pkg::median_t           median_d;

	logic                 out_valid_q;
	rmt_pkg::median_t     median_q;
	rmt_pkg::count_out_t  count_out_q;
	logic                 full_drop_q;

	assign acc        = samples.valid && samples.ready;
	assign ctl.en     = acc && (count_q < rmt_pkg::CNT_W'(rmt_pkg::CAPACITY));
	assign ctl.sample = samples.sample;

	// sorted row
	for (genvar i = 0; i < rmt_pkg::CAPACITY; i++) begin : g_cell
		assign cell_occ[i] = rmt_pkg::CNT_W'(i) < count_q;
		if (i == 0) begin : g_first
			rmt_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.occ      (cell_occ[i]),
				.left_gt  (1'b0),
				.left_val (ctl.sample),
				.val      (cell_val[i]),
				.gt       (cell_gt[i])
			);
		end else begin : g_rest
			rmt_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.occ      (cell_occ[i]),
				.left_gt  (cell_gt[i-1]),
				.left_val (cell_val[i-1]),
				.val      (cell_val[i]),
				.gt       (cell_gt[i])
			);
		end
	end

	for (genvar i = rmt_pkg::CAPACITY; i < rmt_pkg::PAD_DEPTH; i++) begin : g_pad
		assign cell_val[i] = '0;
	end

	// middle positions of the stored values
	assign lo_idx  = rmt_pkg::IDX_W'((count_q - rmt_pkg::CNT_W'(1)) >> 1);
	assign hi_idx  = rmt_pkg::IDX_W'(count_q >> 1);
	assign lo_pidx = rmt_pkg::PIDX_W'(lo_idx);
	assign hi_pidx = rmt_pkg::PIDX_W'(hi_idx);

	// first readout stage: one candidate pair per group
	for (genvar g = 0; g < rmt_pkg::NUM_GROUPS; g++) begin : g_grp
		rmt_pkg::sample_t grp_vals [rmt_pkg::GROUP_SIZE];
		for (genvar k = 0; k < rmt_pkg::GROUP_SIZE; k++) begin : g_tap
			assign grp_vals[k] = cell_val[g*rmt_pkg::GROUP_SIZE + k];
		end
		rmt_group_sel u_sel (
			.clk    (clk),
			.en     (grp_en),
			.lo_sel (lo_pidx[rmt_pkg::GSEL_W-1:0]),
			.hi_sel (hi_pidx[rmt_pkg::GSEL_W-1:0]),
			.vals   (grp_vals),
			.lo_q   (grp_lo[g]),
			.hi_q   (grp_hi[g])
		);
	end

	// second readout stage: pick the group and add
	assign lo_val = grp_lo[lo_pidx[rmt_pkg::PIDX_W-1:rmt_pkg::GSEL_W]];
	assign hi_val = grp_hi[hi_pidx[rmt_pkg::PIDX_W-1:rmt_pkg::GSEL_W]];

	always_comb begin
		if (count_q == '0) begin
			median_d = '0;
		end else begin
			median_d = rmt_pkg::MEDIAN_W'(lo_val) + rmt_pkg::MEDIAN_W'(hi_val);
		end
	end

	always_comb begin
		state_d  = state_q;
		grp_en   = 1'b0;
		fin_load = 1'b0;
		case (state_q)
			rmt_pkg::ST_IDLE: begin
				if (acc) begin
					state_d = rmt_pkg::ST_GRP;
				end
			end
			rmt_pkg::ST_GRP: begin
				grp_en  = 1'b1;
				state_d = rmt_pkg::ST_FIN;
			end
			rmt_pkg::ST_FIN: begin
				if (!out_valid_q || results.ready) begin
					fin_load = 1'b1;
					state_d  = rmt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rmt_pkg::ST_IDLE;
			end
		endcase
	end

	assign samples.ready = (state_q == rmt_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmt_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.en) begin
				count_q <= count_q + rmt_pkg::CNT_W'(1);
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			drop_q <= !ctl.en;
		end
		if (fin_load) begin
			median_q    <= median_d;
			count_out_q <= rmt_pkg::COUNT_OUT_W'(count_q);
			full_drop_q <= drop_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.median_twice = median_q;
	assign results.stored_count = count_out_q;
	assign results.full_drop    = full_drop_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rmt_pkg::CNT_W'(rmt_pkg::CAPACITY))
		else $error("count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (count_q < rmt_pkg::CNT_W'(rmt_pkg::CAPACITY))
		|=> count_q == $past(count_q) + rmt_pkg::CNT_W'(1))
		else $error("count did not advance on insert");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load && drop_q |-> count_q == rmt_pkg::CNT_W'(rmt_pkg::CAPACITY))
		else $error("drop reported with room left");

	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q == rmt_pkg::ST_GRP ##1 state_q == rmt_pkg::ST_FIN)
		else $error("readout sequence broken");

	a_row_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= rmt_pkg::CNT_W'(2) |-> cell_val[0] <= cell_val[1])
		else $error("head of row out of order");
`endif

endmodule

`default_nettype wire

// File: test/rmt_median_checker.sv
`timescale 1ns / 1ps
// rmt_median_checker: watches the sample and result channels, keeps its own sorted store
// and compares every result item against the predicted median, count and full flag
// depends on rmt_pkg and rmt_if

module rmt_median_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	rmt_in_if         samples,
	rmt_out_if        results,
	output int        mismatches,
	output int        pending
);

	import rmt_pkg::*;

	typedef struct packed {
		median_t    median_twice;
		count_out_t stored_count;
		logic       full_drop;
	} median_result_t;

	sample_t        sorted_store [CAPACITY];
	int unsigned    held;
	median_result_t expected_medians [$];
	median_result_t want;
	median_result_t got;

	// insert into the shadow store and work out the result the block should give
	function automatic median_result_t insert_sample(input sample_t value);
		median_result_t r;
		int unsigned    pos;
		median_t        lo;
		median_t        hi;
		r.full_drop = 1'b0;
		if (held >= CAPACITY) begin
			r.full_drop = 1'b1;
		end else begin
			pos = held;
			while (pos > 0 && sorted_store[pos-1] > value) begin
				sorted_store[pos] = sorted_store[pos-1];
				pos--;
			end
			sorted_store[pos] = value;
			held++;
		end
		if (held == 0) begin
			r.median_twice = '0;
		end else if (held % 2 == 1) begin
			lo = sorted_store[held/2];
			r.median_twice = lo + lo;
		end else begin
			lo = sorted_store[held/2 - 1];
			hi = sorted_store[held/2];
			r.median_twice = lo + hi;
		end
		r.stored_count = count_out_t'(held);
		return r;
	endfunction

	task automatic report(input string what, input median_result_t exp_r,
			input median_result_t act_r);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: median_twice exp %0d got %0d, count exp %0d got %0d, full exp %0b got %0b",
				$time, what, exp_r.median_twice, act_r.median_twice,
				exp_r.stored_count, act_r.stored_count, exp_r.full_drop, act_r.full_drop);
	endtask

	initial begin
		mismatches = 0;
		pending    = 0;
		held       = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (samples.valid && samples.ready)
				expected_medians.push_back(insert_sample(samples.sample));
			if (results.valid && results.ready) begin
				got = {results.median_twice, results.stored_count, results.full_drop};
				if (expected_medians.size() == 0) begin
					report("result item with nothing expected", '0, got);
				end else begin
					want = expected_medians.pop_front();
					if (got !== want)
						report("result item mismatch", want, got);
				end
			end
			pending = expected_medians.size();
		end
	end

endmodule

// File: test/tb_running_median_tracker_core.sv
`timescale 1ns / 1ps
// tb_running_median_tracker_core: drives samples with random gaps and result stalls,
// including a long hold-off, and gives the verdict from the checker's mismatch and pending counts
// depends on rmt_pkg, rmt_if, running_median_tracker_core and rmt_median_checker

module tb_running_median_tracker_core;

	import rmt_pkg::*;

	localparam int      TOTAL_ITEMS = 1150;
	localparam int      CALM_TAIL   = 150;
	localparam int      HOLD_AFTER  = 100;
	localparam int      HOLD_CYCLES = 80;
	localparam sample_t SAMPLE_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam sample_t SAMPLE_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};

	logic    clk;
	logic    arst_n;
	logic    calm;
	logic    long_hold;
	int      sent_count;
	int      gap_rate;
	int      errors;
	int      pending;
	sample_t opening [$];
	sample_t history [$];

	rmt_in_if  samples ();
	rmt_out_if results ();

	running_median_tracker_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results)
	);

	rmt_median_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.results    (results),
		.mismatches (errors),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	always #6 clk = ~clk;

	initial begin
		#3_000_000;
		$display("tb_running_median_tracker_core: done, errors");
		$finish;
	end

	// mix of full range, small values with many repeats, extremes and near-repeats
	function automatic sample_t pick_sample();
		int unsigned kind;
		sample_t     v;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			v = $urandom();
		end else if (kind < 70) begin
			v = sample_t'(int'($urandom_range(0, 32)) - 16);
		end else if (kind < 85) begin
			case ($urandom_range(0, 3))
				0: v = SAMPLE_MIN;
				1: v = SAMPLE_MAX;
				2: v = SAMPLE_MIN + sample_t'($urandom_range(0, 3));
				default: v = SAMPLE_MAX - sample_t'($urandom_range(0, 3));
			endcase
		end else begin
			v = history[$urandom_range(0, history.size() - 1)]
				+ sample_t'(int'($urandom_range(0, 2)) - 1);
		end
		return v;
	endfunction

	task automatic send_item(input sample_t value);
		int gap;
		if (!calm && gap_rate != 0 && $urandom_range(0, 3 * gap_rate) == 0) begin
			gap = $urandom_range(1, 5);
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid  <= 1'b1;
		samples.sample <= value;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		sent_count++;
		history.push_back(value);
		if (sent_count % 40 == 0)
			gap_rate = $urandom_range(0, 3);
		calm <= (sent_count >= TOTAL_ITEMS - CALM_TAIL);
	endtask

	// sender
	initial begin
		samples.valid  = 1'b0;
		samples.sample = '0;
		calm           = 1'b0;
		sent_count     = 0;
		gap_rate       = 1;
		opening = '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, '0, -1, 1,
			5, 5, 5, 5, 32'h5555_5555, 32'hAAAA_AAAA, SAMPLE_MIN + 1, SAMPLE_MAX - 1,
			SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, -100, 100, '0, '0};
		@(posedge arst_n);
		@(posedge clk);
		foreach (opening[i])
			send_item(opening[i]);
		while (sent_count < TOTAL_ITEMS)
			send_item(pick_sample());
		samples.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (12) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_running_median_tracker_core: done, clean");
		else
			$display("tb_running_median_tracker_core: done, errors");
		$finish;
	end

	// receiver with stall bursts
	initial begin
		int burst;
		int rate;
		int cycle;
		results.ready = 1'b0;
		burst = 0;
		rate  = 1;
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle % 64 == 0)
				rate = $urandom_range(0, 3);
			if (burst == 0 && !calm && rate != 0 && $urandom_range(0, 4 * rate) == 0)
				burst = $urandom_range(1, 5);
			results.ready <= (burst == 0) && !long_hold;
			if (burst > 0)
				burst--;
		end
	end

	// long result hold-off so the block backs up onto its input
	initial begin
		long_hold = 1'b0;
		wait (sent_count >= HOLD_AFTER);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

endmodule

// File: running_median_tracker_core.f
design/rmt_pkg.sv
design/rmt_if.sv
design/rmt_cell.sv
design/rmt_group_sel.sv
design/running_median_tracker_core.sv
test/rmt_median_checker.sv
test/tb_running_median_tracker_core.sv
